/* rtl/grouped_bit_packing_encoder_unit_defines.svh */
// assertion macros for the grouped bit packing encoder
`ifndef GROUPED_BIT_PACKING_ENCODER_UNIT_DEFINES_SVH
`define GROUPED_BIT_PACKING_ENCODER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define GBPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GBPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GBPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GBPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/gbpe_pkg.sv */
// shared types, constants and helpers of the grouped bit packing encoder
`timescale 1ns / 1ps
package gbpe_pkg;
	localparam int WIDTH_BITS = 6;
	localparam int HDR_FIELD_BITS = 6;
	localparam int GSIZE_BITS = 13;
	localparam int INDEX_BITS = 12;
	localparam logic [GSIZE_BITS-1:0] GSIZE_RESET = 13'd128;
	localparam logic [GSIZE_BITS-1:0] GSIZE_MAX = 13'd4096;
	localparam logic OP_WIDTH = 1'b0;
	localparam logic OP_DATA = 1'b1;
	localparam int REG_GROUP_SIZE = 0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR_DRAIN,
		S_HDR_READ,
		S_DATA,
		S_DAT_DRAIN,
		S_PAD,
		S_FIN
	} state_t;

	typedef struct packed {
		logic width_take;
		logic hdr_start;
		logic data_take;
		logic hdr_append;
		logic data_append;
		logic push_byte;
		logic push_pad;
		logic emit_final;
		logic block_clear;
		logic rd_hdr;
	} cmd_t;

	typedef struct packed {
		logic cnt_ge8;
		logic cnt_nz;
		logic push_ok;
		logic emit_ok;
		logic held_valid;
		logic hdr_more;
	} sts_t;

	function automatic logic [2:0] bit_len6(input logic [WIDTH_BITS-1:0] v);
		logic [2:0] n;
		n = 3'd0;
		for (int i = 0; i < WIDTH_BITS; i++) begin
			if (v[i]) begin
				n = 3'(i + 1);
			end
		end
		return n;
	endfunction
endpackage

/* rtl/gbpe_if.sv */
// request channel interfaces of the grouped bit packing encoder
`timescale 1ns / 1ps
interface gbpe_in_if #(parameter int VALUE_BITS = 32);
	logic valid;
	logic ready;
	logic op;
	logic [5:0] group_width;
	logic signed [VALUE_BITS-1:0] value;
	logic last;
	modport source(output valid, op, group_width, value, last, input ready);
	modport sink(input valid, op, group_width, value, last, output ready);
endinterface

interface gbpe_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic final_byte;
	modport source(output valid, out_byte, final_byte, input ready);
	modport sink(input valid, out_byte, final_byte, output ready);
endinterface

/* rtl/gbpe_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module gbpe_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* rtl/gbpe_ctrl.sv */
// controller state machine of the grouped bit packing encoder
`timescale 1ns / 1ps
module gbpe_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_op,
	input  logic in_last,
	output logic in_ready,
	input  gbpe_pkg::sts_t sts,
	output gbpe_pkg::cmd_t cmd
);
	gbpe_pkg::state_t state_q, state_d;
	logic last_q;
	logic take;

	assign take = in_valid && (state_q == gbpe_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbpe_pkg::S_IDLE;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.data_take) begin
				last_q <= in_last;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbpe_pkg::S_IDLE: begin
				if (take && in_op == gbpe_pkg::OP_DATA) begin
					state_d = gbpe_pkg::S_DATA;
				end else if (take && in_last) begin
					state_d = gbpe_pkg::S_HDR_DRAIN;
				end
			end
			gbpe_pkg::S_HDR_DRAIN: begin
				if (!sts.cnt_ge8) begin
					state_d = sts.hdr_more ? gbpe_pkg::S_HDR_READ : gbpe_pkg::S_IDLE;
				end
			end
			gbpe_pkg::S_HDR_READ: state_d = gbpe_pkg::S_HDR_DRAIN;
			gbpe_pkg::S_DATA: state_d = gbpe_pkg::S_DAT_DRAIN;
			gbpe_pkg::S_DAT_DRAIN: begin
				if (!sts.cnt_ge8) begin
					state_d = last_q ? gbpe_pkg::S_PAD : gbpe_pkg::S_IDLE;
				end
			end
			gbpe_pkg::S_PAD: begin
				if (!sts.cnt_nz || sts.push_ok) begin
					state_d = gbpe_pkg::S_FIN;
				end
			end
			gbpe_pkg::S_FIN: begin
				if (!sts.held_valid || sts.emit_ok) begin
					state_d = gbpe_pkg::S_IDLE;
				end
			end
			default: state_d = gbpe_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			gbpe_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.width_take = take && in_op == gbpe_pkg::OP_WIDTH;
				cmd.hdr_start = take && in_op == gbpe_pkg::OP_WIDTH && in_last;
				cmd.data_take = take && in_op == gbpe_pkg::OP_DATA;
			end
			gbpe_pkg::S_HDR_DRAIN: begin
				cmd.rd_hdr = 1'b1;
				cmd.push_byte = sts.cnt_ge8 && sts.push_ok;
			end
			gbpe_pkg::S_HDR_READ: cmd.hdr_append = 1'b1;
			gbpe_pkg::S_DATA: cmd.data_append = 1'b1;
			gbpe_pkg::S_DAT_DRAIN: cmd.push_byte = sts.cnt_ge8 && sts.push_ok;
			gbpe_pkg::S_PAD: cmd.push_pad = sts.cnt_nz && sts.push_ok;
			gbpe_pkg::S_FIN: begin
				cmd.emit_final = sts.held_valid && sts.emit_ok;
				cmd.block_clear = !sts.held_valid || sts.emit_ok;
			end
			default: cmd = '0;
		endcase
	end
endmodule

/* rtl/gbpe_dpath.sv */
// datapath: width store, bit accumulator, held byte and output register
`timescale 1ns / 1ps
module gbpe_dpath #(
	parameter int MAX_GROUPS = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  gbpe_pkg::cmd_t cmd,
	output gbpe_pkg::sts_t sts,
	input  logic [gbpe_pkg::GSIZE_BITS-1:0] group_size,
	input  logic [gbpe_pkg::WIDTH_BITS-1:0] group_width,
	input  logic [VALUE_BITS-1:0] value,
	input  logic out_ready,
	output logic out_valid,
	output logic [7:0] out_byte,
	output logic final_byte
);
	localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GC_W = $clog2(MAX_GROUPS + 1);
	localparam int ACC_W = VALUE_BITS + 7;
	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam int WB = gbpe_pkg::WIDTH_BITS;
	localparam int GB = gbpe_pkg::GSIZE_BITS;
	localparam int IB = gbpe_pkg::INDEX_BITS;

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0] held_q;
	logic held_vld_q;
	logic out_vld_q;
	logic [7:0] out_byte_q;
	logic out_fin_q;
	logic [GC_W-1:0] loaded_q;
	logic [WB-1:0] largest_q;
	logic [2:0] hw_q;
	logic [GC_W-1:0] gidx_q;
	logic [IB-1:0] iig_q;
	logic [GC_W-1:0] hdr_i_q;
	logic [VALUE_BITS-1:0] val_q;

	logic [WB-1:0] gw_sat;
	logic store_en;
	logic [WB-1:0] largest_nxt;
	logic [2:0] hw_new;
	logic [WB-1:0] rdata;
	logic [AW-1:0] raddr;
	logic hit;
	logic app_en;
	logic [VALUE_BITS-1:0] app_v;
	logic [WB-1:0] app_n;
	logic [VALUE_BITS-1:0] app_mask;
	logic [ACC_W-1:0] acc_app;
	logic [ACC_W-1:0] acc_shr;
	logic [7:0] top_byte;
	logic [7:0] pad_byte;
	logic [2:0] pad_sh;
	logic push;
	logic [7:0] push_val;
	logic out_load;
	logic [GB-1:0] eff_size;
	logic [GB-1:0] iig_nxt;

	assign gw_sat = (group_width > WB'(VALUE_BITS)) ? WB'(VALUE_BITS) : group_width;
	assign store_en = cmd.width_take && (loaded_q < GC_W'(MAX_GROUPS));
	assign largest_nxt = (store_en && gw_sat > largest_q) ? gw_sat : largest_q;
	assign hw_new = (largest_nxt == '0) ? 3'd1 : gbpe_pkg::bit_len6(largest_nxt);

	assign raddr = cmd.rd_hdr ? hdr_i_q[AW-1:0] : gidx_q[AW-1:0];

	gbpe_ram #(.WIDTH(WB), .DEPTH(MAX_GROUPS)) u_wstore (
		.clk(clk),
		.we(store_en),
		.waddr(loaded_q[AW-1:0]),
		.wdata(gw_sat),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign hit = gidx_q < loaded_q;

	// field select for the bit accumulator
	always_comb begin
		app_en = 1'b0;
		app_v = '0;
		app_n = '0;
		if (cmd.hdr_start) begin
			app_en = 1'b1;
			app_v = VALUE_BITS'(hw_new);
			app_n = WB'(gbpe_pkg::HDR_FIELD_BITS);
		end else if (cmd.hdr_append) begin
			app_en = 1'b1;
			app_v = VALUE_BITS'(rdata);
			app_n = WB'(hw_q);
		end else if (cmd.data_append && hit) begin
			app_en = 1'b1;
			app_v = val_q;
			app_n = rdata;
		end
	end

	assign app_mask = (app_n >= WB'(VALUE_BITS)) ? {VALUE_BITS{1'b1}}
		: ((VALUE_BITS'(1) << app_n) - VALUE_BITS'(1));
	assign acc_app = (acc_q << app_n) | ACC_W'(app_v & app_mask);

	assign acc_shr = acc_q >> (cnt_q - CNT_W'(8));
	assign top_byte = acc_shr[7:0];
	assign pad_sh = 3'(4'd8 - {1'b0, cnt_q[2:0]});
	assign pad_byte = acc_q[7:0] << pad_sh;

	assign push = cmd.push_byte || cmd.push_pad;
	assign push_val = cmd.push_pad ? pad_byte : top_byte;
	assign out_load = (push && held_vld_q) || cmd.emit_final;

	assign eff_size = (group_size == '0) ? GB'(1)
		: ((group_size > gbpe_pkg::GSIZE_MAX) ? gbpe_pkg::GSIZE_MAX : group_size);
	assign iig_nxt = {1'b0, iig_q} + GB'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			held_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			loaded_q <= '0;
			largest_q <= '0;
			hw_q <= 3'd1;
			gidx_q <= '0;
			iig_q <= '0;
			hdr_i_q <= '0;
		end else begin
			priority if (app_en) begin
				cnt_q <= cnt_q + CNT_W'(app_n);
			end else if (cmd.push_byte) begin
				cnt_q <= cnt_q - CNT_W'(8);
			end else if (cmd.push_pad || cmd.block_clear) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q;
			end

			if (push) begin
				held_vld_q <= 1'b1;
			end else if (cmd.emit_final) begin
				held_vld_q <= 1'b0;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end

			if (store_en) begin
				loaded_q <= loaded_q + GC_W'(1);
				largest_q <= largest_nxt;
			end

			priority if (cmd.block_clear) begin
				loaded_q <= '0;
				largest_q <= '0;
				gidx_q <= '0;
				iig_q <= '0;
			end else if (cmd.hdr_start) begin
				hw_q <= hw_new;
				hdr_i_q <= '0;
				gidx_q <= '0;
				iig_q <= '0;
			end else if (cmd.hdr_append) begin
				hdr_i_q <= hdr_i_q + GC_W'(1);
			end else if (cmd.data_append && hit) begin
				if (iig_nxt >= eff_size) begin
					iig_q <= '0;
					gidx_q <= gidx_q + GC_W'(1);
				end else begin
					iig_q <= iig_nxt[IB-1:0];
				end
			end else begin
				hdr_i_q <= hdr_i_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (app_en) begin
			acc_q <= acc_app;
		end
		if (push) begin
			held_q <= push_val;
		end
		if (out_load) begin
			out_byte_q <= held_q;
			out_fin_q <= cmd.emit_final;
		end
		if (cmd.data_take) begin
			val_q <= value;
		end
	end

	assign sts.cnt_ge8 = cnt_q >= CNT_W'(8);
	assign sts.cnt_nz = cnt_q != '0;
	assign sts.emit_ok = !out_vld_q || out_ready;
	assign sts.push_ok = !held_vld_q || sts.emit_ok;
	assign sts.held_valid = held_vld_q;
	assign sts.hdr_more = hdr_i_q < loaded_q;

	assign out_valid = out_vld_q;
	assign out_byte = out_byte_q;
	assign final_byte = out_fin_q;
endmodule

/* rtl/grouped_bit_packing_encoder_unit.sv */
// top level of the grouped bit packing encoder
//
// channel  | dir | payload                          | handshake
// din      | in  | op, group_width, value, last     | valid / ready
// dout     | out | out_byte, final_byte             | valid / ready
// apb      | in  | group_size at word 0             | psel / penable, pready high
//
// a width request is taken in idle; the request that closes the width list adds the header
// field, then a width store read and an append per stored width, each followed by a drain of full bytes
// a data request steps through take and width store read, append, and drain check,
// pushing each byte formed; closing the block adds pad and final byte steps
// reset clears control state; the width store is not cleared and needs no pass
// a stalled output holds its register; one byte waits inside until the next is formed or the block closes
`timescale 1ns / 1ps
`include "grouped_bit_packing_encoder_unit_defines.svh"
module grouped_bit_packing_encoder_unit #(
	parameter int MAX_GROUPS = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	gbpe_in_if.sink din,
	gbpe_out_if.source dout,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [gbpe_pkg::GSIZE_BITS-1:0] gsize_q;
	logic reg_hit;
	gbpe_pkg::cmd_t cmd;
	gbpe_pkg::sts_t sts;

	assign pready = 1'b1;
	assign reg_hit = paddr[2] == 1'(gbpe_pkg::REG_GROUP_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q <= gbpe_pkg::GSIZE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			gsize_q <= pwdata[gbpe_pkg::GSIZE_BITS-1:0];
		end
	end

	assign prdata = reg_hit ? 32'(gsize_q) : '0;

	gbpe_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(din.valid),
		.in_op(din.op),
		.in_last(din.last),
		.in_ready(din.ready),
		.sts(sts),
		.cmd(cmd)
	);

	gbpe_dpath #(.MAX_GROUPS(MAX_GROUPS), .VALUE_BITS(VALUE_BITS)) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.group_size(gsize_q),
		.group_width(din.group_width),
		.value(din.value),
		.out_ready(dout.ready),
		.out_valid(dout.valid),
		.out_byte(dout.out_byte),
		.final_byte(dout.final_byte)
	);

	`GBPE_ASSERT_IMP(a_push_has_room, clk, arst_n, cmd.push_byte || cmd.push_pad, sts.push_ok, "byte pushed without room")
	`GBPE_ASSERT_NXT(a_final_empties, clk, arst_n, cmd.emit_final, !sts.held_valid, "held byte left after final")
	`GBPE_ASSERT_IMP(a_idle_drained, clk, arst_n, din.ready, !sts.cnt_ge8, "request taken with a full byte pending")
endmodule

/* verif/grouped_bit_packing_encoder_unit_test.sv */
// self-checking testbench of the grouped bit packing encoder: directed table then random blocks
`timescale 1ns / 1ps
module grouped_bit_packing_encoder_unit_test;

	localparam int N_GROUPS = 64;
	localparam int W_MAX = 32;
	localparam int N_ROWS = 22;
	localparam int QUIET_CYCLES = 300;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic op;
		logic [5:0] group_width;
		logic [31:0] value;
		logic last;
	} pack_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic fin;
	} due_byte_t;

	typedef struct packed {
		logic op;
		logic [5:0] group_width;
		logic [31:0] value;
		logic last;
		logic typed;
		logic has_byte;
		logic [7:0] exp_byte;
		logic exp_fin;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	gbpe_in_if #(.VALUE_BITS(W_MAX)) din_if();
	gbpe_out_if dout_if();

	grouped_bit_packing_encoder_unit #(
		.MAX_GROUPS(N_GROUPS),
		.VALUE_BITS(W_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_if),
		.dout(dout_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// predictor state
	logic [5:0] width_tab [N_GROUPS];
	logic [6:0] n_widths;
	logic [5:0] widest;
	logic [7:0] acc_bits;
	logic [3:0] acc_cnt;
	logic [7:0] hold_byte;
	logic hold_vld;
	logic [6:0] grp;
	logic [12:0] grp_pos;
	logic [12:0] gsize_reg;

	due_byte_t bytes_due [$];
	int mismatches = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_asks = 0;

	dir_row_t dir_rows [N_ROWS] = '{
		'{gbpe_pkg::OP_WIDTH, 6'd0, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'h04, 1'b1},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'h1234_5678, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_WIDTH, 6'd63, 32'hDEAD_BEEF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_WIDTH, 6'd32, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 8'h1A, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd63, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_WIDTH, 6'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_WIDTH, 6'd3, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_WIDTH, 6'd1, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd63, 32'h0000_0005, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_WIDTH, 6'd4, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'h0000_000F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_WIDTH, 6'd7, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'h0000_0055, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'h0000_002A, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{gbpe_pkg::OP_DATA, 6'd0, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}
	};

	function automatic void hand_on(input logic [7:0] b);
		if (hold_vld) begin
			bytes_due.push_back('{hold_byte, 1'b0});
		end
		hold_byte = b;
		hold_vld = 1'b1;
	endfunction

	// append the low n bits of v, msb first
	function automatic void shift_in(input logic [31:0] v, input int n);
		for (int k = n; k > 0; k--) begin
			acc_bits = {acc_bits[6:0], v[k-1]};
			acc_cnt = acc_cnt + 4'd1;
			if (acc_cnt == 4'd8) begin
				hand_on(acc_bits);
				acc_bits = '0;
				acc_cnt = '0;
			end
		end
	endfunction

	function automatic int group_span();
		if (gsize_reg == 13'd0) begin
			return 1;
		end
		if (gsize_reg > gbpe_pkg::GSIZE_MAX) begin
			return int'(gbpe_pkg::GSIZE_MAX);
		end
		return int'(gsize_reg);
	endfunction

	function automatic void pack_request(input pack_req_t r);
		logic [5:0] w;
		logic [5:0] rest;
		int hw;
		w = (r.group_width > 6'(W_MAX)) ? 6'(W_MAX) : r.group_width;
		if (r.op == gbpe_pkg::OP_WIDTH) begin
			if (n_widths < 7'(N_GROUPS)) begin
				width_tab[n_widths] = w;
				n_widths = n_widths + 7'd1;
				if (w > widest) begin
					widest = w;
				end
			end
			if (r.last) begin
				hw = 0;
				rest = widest;
				while (rest != 6'd0) begin
					hw++;
					rest = rest >> 1;
				end
				if (hw == 0) begin
					hw = 1;
				end
				shift_in(32'(hw), gbpe_pkg::HDR_FIELD_BITS);
				for (int i = 0; i < int'(n_widths); i++) begin
					shift_in(32'(width_tab[i]), hw);
				end
				grp = '0;
				grp_pos = '0;
			end
			return;
		end
		if (grp < n_widths) begin
			shift_in(r.value, int'(width_tab[grp]));
			grp_pos = grp_pos + 13'd1;
			if (int'(grp_pos) >= group_span()) begin
				grp_pos = '0;
				grp = grp + 7'd1;
			end
		end
		if (r.last) begin
			if (acc_cnt != 4'd0) begin
				hand_on(acc_bits << (4'd8 - acc_cnt));
				acc_bits = '0;
				acc_cnt = '0;
			end
			if (hold_vld) begin
				bytes_due.push_back('{hold_byte, 1'b1});
				hold_vld = 1'b0;
				hold_byte = '0;
			end
			n_widths = '0;
			widest = '0;
			grp = '0;
			grp_pos = '0;
		end
	endfunction

	// offer one request; returns at the edge that accepts it
	task automatic send_req(input pack_req_t r, input logic typed, input logic has_byte,
			input logic [7:0] eb, input logic ef);
		int n0;
		if ($urandom_range(99) < src_idle_pct) begin
			din_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		din_if.valid <= 1'b1;
		din_if.op <= r.op;
		din_if.group_width <= r.group_width;
		din_if.value <= r.value;
		din_if.last <= r.last;
		@(posedge clk);
		while (!din_if.ready) @(posedge clk);
		n0 = bytes_due.size();
		pack_request(r);
		if (typed) begin
			while (bytes_due.size() > n0) begin
				void'(bytes_due.pop_back());
			end
			if (has_byte) begin
				bytes_due.push_back('{eb, ef});
			end
		end
	endtask

	task automatic drain(input int quiet);
		din_if.valid <= 1'b0;
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (quiet) @(posedge clk);
	endtask

	task automatic apb_read_check(input logic [31:0] exp_val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'(gbpe_pkg::REG_GROUP_SIZE * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== exp_val) begin
			$display("%0t: group_size readback expected %0d got %0d", $time, exp_val, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_group_size(input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(gbpe_pkg::REG_GROUP_SIZE * 4);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		gsize_reg = v[12:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		apb_read_check({19'd0, v[12:0]});
	endtask

	function automatic logic [5:0] pick_width();
		case ($urandom_range(9))
			0: return 6'd0;
			1: return 6'd32;
			2: return 6'($urandom_range(33, 63));
			default: return 6'($urandom_range(1, 31));
		endcase
	endfunction

	task automatic run_phase(input int n_items, input logic [31:0] gsz, input int src_pct,
			input int snk_pct, input bit long_list, input bit pause_mid, input bit hold_off);
		pack_req_t r;
		int sent;
		int blocks;
		int nw;
		int nd;
		int cap;
		set_group_size(gsz);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		if (hold_off) begin
			hold_asks++;
		end
		sent = 0;
		blocks = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				// noise: any field combination
				r.op = 1'($urandom_range(1));
				r.group_width = 6'($urandom_range(63));
				r.value = $urandom();
				r.last = 1'($urandom_range(1));
				send_req(r, 1'b0, 1'b0, 8'h00, 1'b0);
				sent++;
			end else begin
				nw = (long_list && blocks == 0) ? $urandom_range(66, 70) : $urandom_range(1, 6);
				for (int i = 0; i < nw; i++) begin
					r.op = gbpe_pkg::OP_WIDTH;
					r.group_width = pick_width();
					r.value = $urandom();
					r.last = (i == nw - 1);
					send_req(r, 1'b0, 1'b0, 8'h00, 1'b0);
				end
				cap = nw * group_span() + 2;
				nd = $urandom_range(1, (cap < 20) ? cap : 20);
				for (int i = 0; i < nd; i++) begin
					r.op = gbpe_pkg::OP_DATA;
					r.group_width = 6'($urandom_range(63));
					r.value = $urandom();
					r.last = (i == nd - 1);
					send_req(r, 1'b0, 1'b0, 8'h00, 1'b0);
				end
				sent += nw + nd;
				blocks++;
				if (pause_mid && blocks == 2) begin
					drain(0);
				end
			end
		end
		// close whatever block is open
		r.op = gbpe_pkg::OP_DATA;
		r.group_width = '0;
		r.value = $urandom();
		r.last = 1'b1;
		send_req(r, 1'b0, 1'b0, 8'h00, 1'b0);
		drain(QUIET_CYCLES);
	endtask

	// result side: random stalls plus a long hold-off on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		due_byte_t e;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (bytes_due.size() == 0) begin
				$display("%0t: unexpected byte, expected none got %02h final %0b", $time,
					dout_if.out_byte, dout_if.final_byte);
				mismatches++;
			end else begin
				e = bytes_due.pop_front();
				if (dout_if.out_byte !== e.data) begin
					$display("%0t: out_byte expected %02h got %02h", $time, e.data,
						dout_if.out_byte);
					mismatches++;
				end
				if (dout_if.final_byte !== e.fin) begin
					$display("%0t: final_byte expected %0b got %0b", $time, e.fin,
						dout_if.final_byte);
					mismatches++;
				end
			end
		end
	end

	initial begin
		pack_req_t r;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		din_if.valid = 1'b0;
		din_if.op = gbpe_pkg::OP_WIDTH;
		din_if.group_width = '0;
		din_if.value = '0;
		din_if.last = 1'b0;
		dout_if.ready = 1'b0;
		for (int i = 0; i < N_GROUPS; i++) begin
			width_tab[i] = '0;
		end
		n_widths = '0;
		widest = '0;
		acc_bits = '0;
		acc_cnt = '0;
		hold_byte = '0;
		hold_vld = 1'b0;
		grp = '0;
		grp_pos = '0;
		gsize_reg = gbpe_pkg::GSIZE_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read_check({19'd0, gbpe_pkg::GSIZE_RESET});

		// directed table, zero group size acts as one
		set_group_size(32'd0);
		src_idle_pct = 34;
		snk_idle_pct = 68;
		for (int i = 0; i < N_ROWS; i++) begin
			r.op = dir_rows[i].op;
			r.group_width = dir_rows[i].group_width;
			r.value = dir_rows[i].value;
			r.last = dir_rows[i].last;
			send_req(r, dir_rows[i].typed, dir_rows[i].has_byte, dir_rows[i].exp_byte,
				dir_rows[i].exp_fin);
		end
		drain(QUIET_CYCLES);

		run_phase(20, 32'd1, 34, 68, 1'b0, 1'b0, 1'b0);
		run_phase(47, 32'd3, 34, 68, 1'b1, 1'b1, 1'b0);
		run_phase(20, 32'd8191, 68, 34, 1'b0, 1'b0, 1'b0);
		run_phase(20, 32'd4096, 68, 34, 1'b0, 1'b1, 1'b0);
		run_phase(20, 32'd2, 0, 0, 1'b0, 1'b0, 1'b1);
		run_phase(47, 32'($urandom_range(1, 16)), 0, 0, 1'b1, 1'b0, 1'b0);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
